FILE: rtl/core/bracket_balance_checker_unit_assert.svh
// Assertion macros shared by the RTL of the bracket checker.
`ifndef BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BBC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

   localparam int STACK_DEPTH_DEF   = 32;
   localparam int POSITION_BITS_DEF = 16;

   localparam logic OP_TEXT = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [2:0] {
      KIND_UNMATCHED = 3'd0,
      KIND_MISMATCH  = 3'd1,
      KIND_UNCLOSED  = 3'd2,
      KIND_OVERFLOW  = 3'd3,
      KIND_DONE      = 3'd4
   } kind_type;

   // One result word as held in the output register.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] issue_line;
      logic [15:0] issue_column;
      logic [7:0]  bracket_byte;
      logic [7:0]  opener_byte;
      logic [15:0] opener_line;
      logic        last;
   } rsp_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic logic is_open(input logic [7:0] b);
      return (b == CH_LPAREN) || (b == CH_LBRACK) || (b == CH_LBRACE);
   endfunction

   function automatic logic is_close(input logic [7:0] b);
      return (b == CH_RPAREN) || (b == CH_RBRACK) || (b == CH_RBRACE);
   endfunction

   function automatic logic [7:0] opener_of(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         CH_RPAREN: r = CH_LPAREN;
         CH_RBRACK: r = CH_LBRACK;
         default:   r = CH_LBRACE;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/core/bbc_stack_ram.sv
`timescale 1ns / 1ps

module bbc_stack_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5,
   parameter int EW    = 40
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data
);

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bracket_balance_checker_unit.sv
`timescale 1ns / 1ps

// Channel   Ports   tdata (low bit up)                               tuser / tlast
// -------   -----   ----------------------------------------------   ---------------
// input     req_    text_byte[7:0]                                   opcode / -
// result    rsp_    line[15:0] col[31:16] byte[39:32]                kind[2:0] / last
//                   opener_byte[47:40] opener_line[63:48]
//
// A closing bracket with a pending opener goes through a check state, since the
// top entry comes out of the stack RAM in the cycle after accept. End of text
// drains one unclosed word per pending opener and then the done word, waiting
// whenever the result register cannot take a word.
// Reset is synchronous; the stack RAM is not cleared, only its count.
// Input is held off whenever the result register is full and not being taken.

module bracket_balance_checker_unit #(
   parameter int STACK_DEPTH   = bbc_pkg::STACK_DEPTH_DEF,
   parameter int POSITION_BITS = bbc_pkg::POSITION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic [0:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // issue_line, issue_column, bracket_byte,
                                    // opener_byte, opener_line
   output logic [2:0]  rsp_tuser,   // issue_kind
   output logic        rsp_tlast    // last_of_run
);

   import bbc_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int PB = POSITION_BITS;
   localparam int EW = 8 + 2 * PB;
   localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DRAIN
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PB-1:0] line_ff, line_in;
   logic [PB-1:0] col_ff, col_in;
   logic          seen_ff, seen_in;
   logic          comment_ff, comment_in;
   logic [7:0]    close_ff, close_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // Stack RAM side.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic [CW-1:0] count_dec;

   // Top entry fields as read from the RAM.
   logic [7:0]    top_byte;
   logic [PB-1:0] top_line;
   logic [PB-1:0] top_col;

   logic          slot_free;
   logic          accept;
   logic [7:0]    rx_byte;
   logic [PB-1:0] col_nx;
   logic          seen_nx;
   logic          comment_nx;

   // 16-bit views of position counters for the result fields.
   logic [31:0]   line_w, col_nx_w, col_w, top_line_w, top_col_w;
   logic [15:0]   line16, col_nx16, col16, top_line16, top_col16;

   assign top_byte = rd_data[EW-1 -: 8];
   assign top_line = rd_data[2*PB-1 -: PB];
   assign top_col  = rd_data[PB-1:0];

   assign line_w     = 32'(line_ff);
   assign col_nx_w   = 32'(col_nx);
   assign col_w      = 32'(col_ff);
   assign top_line_w = 32'(top_line);
   assign top_col_w  = 32'(top_col);
   assign line16     = line_w[15:0];
   assign col_nx16   = col_nx_w[15:0];
   assign col16      = col_w[15:0];
   assign top_line16 = top_line_w[15:0];
   assign top_col16  = top_col_w[15:0];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rx_byte    = req_tdata;

   // Position update for a non-newline text byte.
   always_comb begin
      col_nx     = (col_ff != POS_MAX) ? col_ff + 1'b1 : col_ff;
      seen_nx    = seen_ff;
      comment_nx = comment_ff;
      if (!seen_ff && !is_space(rx_byte)) begin
         seen_nx = 1'b1;
         if (rx_byte == CH_HASH) begin
            comment_nx = 1'b1;
         end
      end
   end

   // Point the read port at the entry that will be on top next cycle; after a pop
   // the new top is ready in the cycle after, but a push first reads the old word.
   assign count_dec = count_in - 1'b1;
   assign rd_addr   = (count_in == '0) ? '0 : AW'(count_dec);
   assign wr_addr   = AW'(count_ff);
   assign wr_data   = {rx_byte, line_ff, col_nx};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      seen_in      = seen_ff;
      comment_in   = comment_ff;
      close_in     = close_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == OP_END) begin
                  state_in = ST_DRAIN;
               end else if (rx_byte == CH_NL) begin
                  line_in    = (line_ff != POS_MAX) ? line_ff + 1'b1 : line_ff;
                  col_in     = '0;
                  seen_in    = 1'b0;
                  comment_in = 1'b0;
               end else begin
                  col_in     = col_nx;
                  seen_in    = seen_nx;
                  comment_in = comment_nx;
                  if (!comment_nx && is_open(rx_byte)) begin
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        // Drop the opener, flag overflow.
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{KIND_OVERFLOW, line16, col_nx16, rx_byte,
                                         8'h00, 16'h0000, 1'b1};
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end else if (!comment_nx && is_close(rx_byte)) begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{KIND_UNMATCHED, line16, col_nx16, rx_byte,
                                         8'h00, 16'h0000, 1'b1};
                     end else begin
                        close_in = rx_byte;
                        state_in = ST_CHECK;
                     end
                  end
               end
            end
         end
         ST_CHECK: begin
            // Top entry is on the read port now; pop it either way.
            count_in = count_ff - 1'b1;
            state_in = ST_IDLE;
            if (top_byte != opener_of(close_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_MISMATCH, line16, col16, close_ff,
                                top_byte, top_line16, 1'b1};
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
                  rsp_in   = '{KIND_UNCLOSED, top_line16, top_col16, top_byte,
                               8'h00, 16'h0000, 1'b0};
               end else begin
                  // Done record; return to the start-of-text state.
                  rsp_in     = '{KIND_DONE, 16'h0000, 16'h0000, 8'h00,
                                 8'h00, 16'h0000, 1'b1};
                  line_in    = PB'(1);
                  col_in     = '0;
                  seen_in    = 1'b0;
                  comment_in = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         line_ff      <= PB'(1);
         col_ff       <= '0;
         seen_ff      <= 1'b0;
         comment_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         seen_ff      <= seen_in;
         comment_ff   <= comment_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      close_ff <= close_in;
      rsp_ff   <= rsp_in;
   end

   bbc_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW),
      .EW    (EW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {rsp_ff.opener_line, rsp_ff.opener_byte, rsp_ff.bracket_byte,
                        rsp_ff.issue_column, rsp_ff.issue_line};

`include "bracket_balance_checker_unit_assert.svh"

   `BBC_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
      count_ff <= CW'(STACK_DEPTH), "stack count beyond depth")
   `BBC_ASSERT_IMPLY(a_done_empty, clock, reset,
      rsp_valid_ff && (rsp_ff.kind == KIND_DONE), count_ff == '0,
      "done record with openers still pending")
   `BBC_ASSERT_NEXT(a_check_pops, clock, reset, state_ff == ST_CHECK,
      (count_ff + 1'b1) == $past(count_ff), "close check did not pop")
   `BBC_ASSERT_NEXT(a_drain_done, clock, reset,
      (state_ff == ST_DRAIN) && (count_ff == '0) && slot_free,
      rsp_valid_ff && rsp_ff.last && (state_ff == ST_IDLE),
      "drain end without final done record")

endmodule
